// ----- rtl/core/lookat_view_matrix_unit_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef LOOKAT_VIEW_MATRIX_UNIT_MACROS_SVH
`define LOOKAT_VIEW_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication.
`define LVM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lvm: same-cycle check failed");

// Next-cycle implication.
`define LVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lvm: next-cycle check failed");

`endif

// ----- rtl/core/lvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_pkg
// Shared types, state encodings and the multiply-accumulate term table.
// ----------------------------------------------------------------------------
package lvm_pkg;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   localparam logic [4:0] TERM_CROSS_LAST = 5'd5;
   localparam logic [4:0] TERM_LAST       = 5'd20;

   typedef struct packed {
      logic [2:0][31:0] eye;
      logic [2:0][31:0] up;
      logic [2:0][32:0] diff;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic done;
      logic zero;
   } nstat_type;

   typedef enum logic [3:0] {
      B_IDLE, B_NF_GO, B_NF_WAIT, B_CROSS, B_CWAIT, B_NS_GO, B_NS_WAIT,
      B_DOTS, B_DWAIT, B_SAT, B_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SCALE, N_SQ, N_SQRT, N_DINIT, N_DSTEP, N_DONE
   } norm_state_type;

   typedef enum logic [2:0] {OP_F, OP_S, OP_U, OP_UP, OP_EYE} opnd_type;
   typedef enum logic [1:0] {DST_NONE, DST_C, DST_U, DST_W} dest_type;

   typedef struct packed {
      opnd_type   a_op;
      logic [1:0] a_idx;
      opnd_type   b_op;
      logic [1:0] b_idx;
      logic       neg;
      logic       first;
      dest_type   dest;
      logic [1:0] d_idx;
   } term_type;

   function automatic term_type mk(opnd_type a, int ai, opnd_type b, int bi,
                                   logic n, logic f, dest_type d, int di);
      term_type t;
      t.a_op  = a;
      t.a_idx = 2'(ai);
      t.b_op  = b;
      t.b_idx = 2'(bi);
      t.neg   = n;
      t.first = f;
      t.dest  = d;
      t.d_idx = 2'(di);
      return t;
   endfunction

   // Product terms: cross f x up, then u = s x f, then the three dot products.
   // The s.eye and u.eye terms are negated so the rounded sum is the word.
   function automatic term_type term_rom(logic [4:0] idx);
      term_type t;
      unique case (idx)
         5'd0:    t = mk(OP_F, 1, OP_UP, 2, 1'b0, 1'b1, DST_NONE, 0);
         5'd1:    t = mk(OP_F, 2, OP_UP, 1, 1'b1, 1'b0, DST_C, 0);
         5'd2:    t = mk(OP_F, 2, OP_UP, 0, 1'b0, 1'b1, DST_NONE, 0);
         5'd3:    t = mk(OP_F, 0, OP_UP, 2, 1'b1, 1'b0, DST_C, 1);
         5'd4:    t = mk(OP_F, 0, OP_UP, 1, 1'b0, 1'b1, DST_NONE, 0);
         5'd5:    t = mk(OP_F, 1, OP_UP, 0, 1'b1, 1'b0, DST_C, 2);
         5'd6:    t = mk(OP_S, 1, OP_F, 2, 1'b0, 1'b1, DST_NONE, 0);
         5'd7:    t = mk(OP_F, 1, OP_S, 2, 1'b1, 1'b0, DST_U, 0);
         5'd8:    t = mk(OP_S, 2, OP_F, 0, 1'b0, 1'b1, DST_NONE, 0);
         5'd9:    t = mk(OP_F, 2, OP_S, 0, 1'b1, 1'b0, DST_U, 1);
         5'd10:   t = mk(OP_S, 0, OP_F, 1, 1'b0, 1'b1, DST_NONE, 0);
         5'd11:   t = mk(OP_F, 0, OP_S, 1, 1'b1, 1'b0, DST_U, 2);
         5'd12:   t = mk(OP_S, 0, OP_EYE, 0, 1'b1, 1'b1, DST_NONE, 0);
         5'd13:   t = mk(OP_S, 1, OP_EYE, 1, 1'b1, 1'b0, DST_NONE, 0);
         5'd14:   t = mk(OP_S, 2, OP_EYE, 2, 1'b1, 1'b0, DST_W, 0);
         5'd15:   t = mk(OP_U, 0, OP_EYE, 0, 1'b1, 1'b1, DST_NONE, 0);
         5'd16:   t = mk(OP_U, 1, OP_EYE, 1, 1'b1, 1'b0, DST_NONE, 0);
         5'd17:   t = mk(OP_U, 2, OP_EYE, 2, 1'b1, 1'b0, DST_W, 1);
         5'd18:   t = mk(OP_F, 0, OP_EYE, 0, 1'b0, 1'b1, DST_NONE, 0);
         5'd19:   t = mk(OP_F, 1, OP_EYE, 1, 1'b0, 1'b0, DST_NONE, 0);
         5'd20:   t = mk(OP_F, 2, OP_EYE, 2, 1'b0, 1'b0, DST_W, 2);
         default: t = mk(OP_F, 0, OP_F, 0, 1'b0, 1'b1, DST_NONE, 0);
      endcase
      return t;
   endfunction

endpackage

// ----- rtl/core/lvm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_front
// Accepts items, forms target - eye and pushes the item into the queue.
// ----------------------------------------------------------------------------
module lvm_front
   import lvm_pkg::*;
(
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_up_x,
   input  logic signed [31:0] req_up_y,
   input  logic signed [31:0] req_up_z,
   input  qstat_type          qstat,
   output logic               push,
   output item_type           entry
);

   assign busy = qstat.full;
   assign push = start & ~qstat.full;

   always_comb begin
      entry.eye     = {req_eye_z, req_eye_y, req_eye_x};
      entry.up      = {req_up_z, req_up_y, req_up_x};
      entry.diff[0] = {req_target_x[31], req_target_x} - {req_eye_x[31], req_eye_x};
      entry.diff[1] = {req_target_y[31], req_target_y} - {req_eye_y[31], req_eye_y};
      entry.diff[2] = {req_target_z[31], req_target_z} - {req_eye_z[31], req_eye_z};
   end

endmodule

// ----- rtl/core/lvm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module lvm_queue
   import lvm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  din,
   input  logic      pop,
   output item_type  dout,
   output qstat_type qstat
);

   item_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign qstat.empty = (cnt_ff == '0);

endmodule

// ----- rtl/core/lvm_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_norm
// Iterative vector normalizer: scale, sum of squares, bitwise square root,
// restoring divide per component.
// ----------------------------------------------------------------------------
module lvm_norm
   import lvm_pkg::*;
#(
   parameter  int FRAC_BITS = 16,
   localparam int VW = FRAC_BITS + 3,
   localparam int NW = VW + 34,
   localparam int CW = $clog2(FRAC_BITS + 1)
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] vec [3],
   output logic signed [VW-1:0] res [3],
   output nstat_type            stat
);

   norm_state_type st_ff, st_in;

   logic [NW-1:0]        m_ff [3];
   logic [2:0]           sgn_ff;
   logic [1:0]           k_ff;
   logic [CW-1:0]        cnt_ff;
   logic [59:0]          sq_ff;
   logic [61:0]          sum_ff;
   logic [63:0]          x_ff, root_ff, bit_ff;
   logic [31:0]          n_ff, rem_ff;
   logic [FRAC_BITS:0]   low_ff, q_ff;
   logic signed [VW-1:0] res_ff [3];
   logic                 zero_ff;

   logic [NW-1:0]      orv;
   logic               too_big, too_small, is_zero;
   logic [29:0]        m_lo;
   logic [59:0]        sq_c;
   logic [63:0]        sq_t;
   logic               sq_ge;
   logic [63:0]        numer;
   logic [32:0]        dt;
   logic               dge;
   logic [FRAC_BITS:0] qn;
   logic               div_last;

   always_comb begin
      orv       = m_ff[0] | m_ff[1] | m_ff[2];
      is_zero   = (orv == '0);
      too_big   = |orv[NW-1:30];
      too_small = ~orv[29];
      m_lo      = m_ff[k_ff][29:0];
      sq_c      = m_lo * m_lo;
      sq_t      = root_ff + bit_ff;
      sq_ge     = (x_ff >= sq_t);
      numer     = (64'(m_lo) << FRAC_BITS) + 64'(n_ff >> 1);
      dt        = {rem_ff, low_ff[FRAC_BITS]};
      dge       = (dt >= {1'b0, n_ff});
      qn        = {q_ff[FRAC_BITS-1:0], dge};
      div_last  = (cnt_ff == CW'(FRAC_BITS));
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         N_IDLE:  if (start) st_in = N_SCALE;
         N_SCALE: begin
            if (is_zero) st_in = N_DONE;
            else if (!too_big && !too_small) st_in = N_SQ;
         end
         N_SQ:    if (k_ff == 2'd3) st_in = N_SQRT;
         N_SQRT:  if (bit_ff[0]) st_in = N_DINIT;
         N_DINIT: st_in = N_DSTEP;
         N_DSTEP: begin
            if (div_last) st_in = (k_ff == 2'd2) ? N_DONE : N_DINIT;
         end
         N_DONE:  st_in = N_IDLE;
         default: st_in = N_IDLE;
      endcase
   end

   always_comb begin
      stat.done = (st_ff == N_DONE);
      stat.zero = zero_ff;
      res       = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= N_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i]   <= vec[i][NW-1] ? NW'(-vec[i]) : NW'(vec[i]);
                  sgn_ff[i] <= vec[i][NW-1];
               end
               zero_ff <= 1'b0;
            end
         end
         N_SCALE: begin
            k_ff   <= 2'd0;
            sum_ff <= '0;
            if (is_zero) begin
               zero_ff <= 1'b1;
               for (int i = 0; i < 3; i++) res_ff[i] <= '0;
            end else if (too_big) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
            end else if (too_small) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
            end
         end
         N_SQ: begin
            if (k_ff != 2'd3) sq_ff <= sq_c;
            if (k_ff != 2'd0) sum_ff <= sum_ff + 62'(sq_ff);
            k_ff    <= k_ff + 2'd1;
            x_ff    <= 64'(sum_ff) + 64'(sq_ff);
            root_ff <= '0;
            bit_ff  <= 64'(1) << 62;
         end
         N_SQRT: begin
            if (sq_ge) begin
               x_ff    <= x_ff - sq_t;
               root_ff <= (root_ff >> 1) + bit_ff;
               n_ff    <= 32'((root_ff >> 1) + bit_ff);
            end else begin
               root_ff <= root_ff >> 1;
               n_ff    <= 32'(root_ff >> 1);
            end
            bit_ff <= bit_ff >> 2;
            k_ff   <= 2'd0;
         end
         N_DINIT: begin
            rem_ff <= 32'(numer >> (FRAC_BITS + 1));
            low_ff <= numer[FRAC_BITS:0];
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         N_DSTEP: begin
            rem_ff <= dge ? 32'(dt - {1'b0, n_ff}) : dt[31:0];
            q_ff   <= qn;
            low_ff <= low_ff << 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (div_last) begin
               res_ff[k_ff] <= sgn_ff[k_ff] ? -$signed(VW'(qn)) : $signed(VW'(qn));
               k_ff         <= k_ff + 2'd1;
            end
         end
         N_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/core/lvm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_back
// Sequencer: two normalizations, a multiply-accumulate pass over the
// product terms, saturation and the four result groups.
// ----------------------------------------------------------------------------
module lvm_back
   import lvm_pkg::*;
#(
   parameter  int FRAC_BITS = 16,
   localparam int VW = FRAC_BITS + 3,
   localparam int PW = VW + 32,
   localparam int AW = PW + 2,
   localparam int NW = VW + 34
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  qstat_type            qstat,
   input  item_type             q_head,
   output logic                 pop,
   output logic                 norm_start,
   output logic signed [NW-1:0] norm_vec [3],
   input  logic signed [VW-1:0] norm_res [3],
   input  nstat_type            nstat,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_group_index,
   output logic signed [31:0]   rsp_word0,
   output logic signed [31:0]   rsp_word1,
   output logic signed [31:0]   rsp_word2,
   output logic signed [31:0]   rsp_word3,
   output logic                 rsp_degenerate,
   output logic                 rsp_final_group
);

   function automatic logic signed [AW-1:0] shr_round(logic signed [AW-1:0] v);
      logic [AW-1:0] mag;
      logic [AW-1:0] r;
      mag = v[AW-1] ? AW'(-v) : AW'(v);
      r   = (mag + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[AW-1] ? -$signed(r) : $signed(r);
   endfunction

   // {overflow, clamped word}
   function automatic logic [32:0] sat32(logic signed [AW-1:0] v);
      logic [AW-32:0] hi;
      hi = v[AW-1:31];
      if (hi == '0 || hi == '1) return {1'b0, v[31:0]};
      return {1'b1, v[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
   endfunction

   back_state_type st_ff, st_in;

   logic signed [31:0]   eye_ff [3];
   logic signed [31:0]   up_ff  [3];
   logic signed [32:0]   d_ff   [3];
   logic signed [VW-1:0] f_ff   [3];
   logic signed [VW-1:0] s_ff   [3];
   logic signed [VW-1:0] u_ff   [3];
   logic signed [AW-1:0] c_ff   [3];
   logic signed [AW-1:0] w3_ff  [3];
   logic signed [31:0]   wu_ff  [3];
   logic signed [31:0]   w3s_ff [3];
   logic                 deg_ff;
   logic [4:0]           term_ff;
   logic [1:0]           grp_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   term_type             mterm_ff;
   logic                 mvld_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_group_ff, rsp_group_in;
   logic signed [31:0]   rsp_w0_ff, rsp_w0_in, rsp_w1_ff, rsp_w1_in;
   logic signed [31:0]   rsp_w2_ff, rsp_w2_in, rsp_w3_ff, rsp_w3_in;
   logic                 rsp_deg_ff, rsp_deg_in, rsp_fin_ff, rsp_fin_in;

   logic                 issue;
   term_type             cur;
   logic signed [VW-1:0] a_val;
   logic signed [31:0]   b_val;
   logic signed [PW-1:0] prod_c;
   logic signed [AW-1:0] addend, acc_next, rnd_c;
   logic [32:0]          sat_u [3];
   logic [32:0]          sat_w [3];
   logic                 sat_any;

   // operand fetch and product
   always_comb begin
      cur = term_rom(term_ff);
      unique case (cur.a_op)
         OP_F:    a_val = f_ff[cur.a_idx];
         OP_S:    a_val = s_ff[cur.a_idx];
         OP_U:    a_val = u_ff[cur.a_idx];
         default: a_val = '0;
      endcase
      unique case (cur.b_op)
         OP_UP:   b_val = up_ff[cur.b_idx];
         OP_EYE:  b_val = eye_ff[cur.b_idx];
         OP_F:    b_val = 32'(f_ff[cur.b_idx]);
         OP_S:    b_val = 32'(s_ff[cur.b_idx]);
         default: b_val = '0;
      endcase
      prod_c   = a_val * b_val;
      addend   = mterm_ff.neg ? -AW'(prod_ff) : AW'(prod_ff);
      acc_next = (mterm_ff.first ? AW'(0) : acc_ff) + addend;
      rnd_c    = shr_round(acc_next);
      sat_any  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         sat_u[i] = sat32(AW'(u_ff[i]));
         sat_w[i] = sat32(w3_ff[i]);
         sat_any  = sat_any | sat_u[i][32] | sat_w[i][32];
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         B_IDLE:    if (!qstat.empty) st_in = B_NF_GO;
         B_NF_GO:   st_in = B_NF_WAIT;
         B_NF_WAIT: if (nstat.done) st_in = B_CROSS;
         B_CROSS:   if (term_ff == TERM_CROSS_LAST) st_in = B_CWAIT;
         B_CWAIT:   st_in = B_NS_GO;
         B_NS_GO:   st_in = B_NS_WAIT;
         B_NS_WAIT: if (nstat.done) st_in = B_DOTS;
         B_DOTS:    if (term_ff == TERM_LAST) st_in = B_DWAIT;
         B_DWAIT:   st_in = B_SAT;
         B_SAT:     st_in = B_EMIT;
         B_EMIT:    if (grp_ff == 2'd3) st_in = B_IDLE;
         default:   st_in = B_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop          = (st_ff == B_IDLE) && !qstat.empty;
      norm_start   = (st_ff == B_NF_GO) || (st_ff == B_NS_GO);
      issue        = (st_ff == B_CROSS) || (st_ff == B_DOTS);
      for (int i = 0; i < 3; i++) begin
         norm_vec[i] = (st_ff == B_NS_GO) ? c_ff[i] : NW'(d_ff[i]);
      end
      rsp_valid_in = (st_ff == B_EMIT);
      rsp_group_in = grp_ff;
      rsp_deg_in   = deg_ff;
      rsp_fin_in   = (grp_ff == 2'd3);
      if (grp_ff == 2'd3) begin
         rsp_w0_in = w3s_ff[0];
         rsp_w1_in = w3s_ff[1];
         rsp_w2_in = w3s_ff[2];
         rsp_w3_in = 32'(1) << FRAC_BITS;
      end else begin
         rsp_w0_in = 32'(s_ff[grp_ff]);
         rsp_w1_in = wu_ff[grp_ff];
         rsp_w2_in = 32'(-f_ff[grp_ff]);
         rsp_w3_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         term_ff      <= '0;
         grp_ff       <= '0;
         mvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         mvld_ff      <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) term_ff <= '0;
         else if (issue) term_ff <= term_ff + 5'd1;
         if (st_ff == B_EMIT) grp_ff <= grp_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < 3; i++) begin
            eye_ff[i] <= $signed(q_head.eye[i]);
            up_ff[i]  <= $signed(q_head.up[i]);
            d_ff[i]   <= $signed(q_head.diff[i]);
         end
         deg_ff <= 1'b0;
      end
      if (st_ff == B_NF_WAIT && nstat.done) begin
         f_ff   <= norm_res;
         deg_ff <= deg_ff | nstat.zero;
      end
      if (st_ff == B_NS_WAIT && nstat.done) begin
         s_ff   <= norm_res;
         deg_ff <= deg_ff | nstat.zero;
      end
      if (issue) begin
         prod_ff  <= prod_c;
         mterm_ff <= cur;
      end
      if (mvld_ff) begin
         acc_ff <= acc_next;
         unique case (mterm_ff.dest)
            DST_C:    c_ff[mterm_ff.d_idx]  <= acc_next;
            DST_U:    u_ff[mterm_ff.d_idx]  <= VW'(rnd_c);
            DST_W:    w3_ff[mterm_ff.d_idx] <= rnd_c;
            DST_NONE: begin
            end
            default: begin
            end
         endcase
      end
      if (st_ff == B_SAT) begin
         for (int i = 0; i < 3; i++) begin
            wu_ff[i]  <= sat_u[i][31:0];
            w3s_ff[i] <= sat_w[i][31:0];
         end
         deg_ff <= deg_ff | sat_any;
      end
      rsp_group_ff <= rsp_group_in;
      rsp_w0_ff    <= rsp_w0_in;
      rsp_w1_ff    <= rsp_w1_in;
      rsp_w2_ff    <= rsp_w2_in;
      rsp_w3_ff    <= rsp_w3_in;
      rsp_deg_ff   <= rsp_deg_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_group_index = rsp_group_ff;
   assign rsp_word0       = rsp_w0_ff;
   assign rsp_word1       = rsp_w1_ff;
   assign rsp_word2       = rsp_w2_ff;
   assign rsp_word3       = rsp_w3_ff;
   assign rsp_degenerate  = rsp_deg_ff;
   assign rsp_final_group = rsp_fin_ff;

endmodule

// ----- rtl/core/lookat_view_matrix_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookat_view_matrix_unit
// Fixed-point look-at view matrix builder, four result groups per item.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low; busy rises
// only when the two-entry input queue is full, so two items can be loaded
// while a third is being computed. Each item produces four results on
// back-to-back cycles, each marked by rsp_valid for one cycle: groups 0..2
// hold (s, u, -f, 0) for x, y, z and group 3 holds (-s.eye, -u.eye, f.eye, 1)
// with rsp_final_group set. The sink must take every result as it appears:
// there is no way to hold results off. The back end works on one item at a
// time and is set by the normalize unit, which runs twice per item and
// iterates one bit per cycle through its scaling shifter, its 32-step square
// root and three (FRAC_BITS+1)-step divides; a zero vector skips the square
// root and the divides. Around that the sequencer pops the item, launches
// the normalizer, runs the 21 product terms, saturates and emits the four
// result groups. rsp_degenerate is the same on all four results and flags a
// zero-length vector or a saturated word.
// ----------------------------------------------------------------------------
module lookat_view_matrix_unit
   import lvm_pkg::*;
#(
   parameter int FRAC_BITS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_up_x,
   input  logic signed [31:0] req_up_y,
   input  logic signed [31:0] req_up_z,
   output logic               rsp_valid,
   output logic [1:0]         rsp_group_index,
   output logic signed [31:0] rsp_word0,
   output logic signed [31:0] rsp_word1,
   output logic signed [31:0] rsp_word2,
   output logic signed [31:0] rsp_word3,
   output logic               rsp_degenerate,
   output logic               rsp_final_group
);

   localparam int VW = FRAC_BITS + 3;
   localparam int NW = VW + 34;

   qstat_type            qstat;
   item_type             q_in, q_head;
   logic                 push, pop;
   logic                 norm_start;
   logic signed [NW-1:0] norm_vec [3];
   logic signed [VW-1:0] norm_res [3];
   nstat_type            nstat;

   // front: accept and form target - eye
   lvm_front u_front (
      .start        (start),
      .busy         (busy),
      .req_eye_x    (req_eye_x),
      .req_eye_y    (req_eye_y),
      .req_eye_z    (req_eye_z),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_target_z (req_target_z),
      .req_up_x     (req_up_x),
      .req_up_y     (req_up_y),
      .req_up_z     (req_up_z),
      .qstat        (qstat),
      .push         (push),
      .entry        (q_in)
   );

   // decoupling queue
   lvm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (q_in),
      .pop   (pop),
      .dout  (q_head),
      .qstat (qstat)
   );

   // shared normalizer, used for f and then for s
   lvm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec   (norm_vec),
      .res   (norm_res),
      .stat  (nstat)
   );

   // back: sequencing, multiply-accumulate, result groups
   lvm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .q_head          (q_head),
      .pop             (pop),
      .norm_start      (norm_start),
      .norm_vec        (norm_vec),
      .norm_res        (norm_res),
      .nstat           (nstat),
      .rsp_valid       (rsp_valid),
      .rsp_group_index (rsp_group_index),
      .rsp_word0       (rsp_word0),
      .rsp_word1       (rsp_word1),
      .rsp_word2       (rsp_word2),
      .rsp_word3       (rsp_word3),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_final_group (rsp_final_group)
   );

endmodule

// ----- rtl/core/lvm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_checker
// Port-level checks on the result stream of the view matrix unit.
// ----------------------------------------------------------------------------
`include "lookat_view_matrix_unit_macros.svh"

module lvm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [1:0] rsp_group_index,
   input logic       rsp_degenerate,
   input logic       rsp_final_group
);

   // final flag marks group 3 and nothing else
   `LVM_ASSERT_SAME(a_final_is_g3, clock, reset, rsp_valid, rsp_final_group == (rsp_group_index == 2'd3))

   // groups of one matrix come on consecutive cycles, in order
   `LVM_ASSERT_NEXT(a_grp_seq, clock, reset, rsp_valid && !rsp_final_group, rsp_valid && (rsp_group_index == 2'($past(rsp_group_index) + 2'd1)))

   // degenerate flag is the same for all groups of one matrix
   `LVM_ASSERT_NEXT(a_deg_hold, clock, reset, rsp_valid && !rsp_final_group, rsp_degenerate == $past(rsp_degenerate))

   // the stream pauses after the last group
   `LVM_ASSERT_NEXT(a_gap_after, clock, reset, rsp_valid && rsp_final_group, !rsp_valid)

endmodule

bind lookat_view_matrix_unit lvm_checker u_lvm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_group_index (rsp_group_index),
   .rsp_degenerate  (rsp_degenerate),
   .rsp_final_group (rsp_final_group)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Look-at view matrix unit testbench
// Drives eye, target and up items through the start/busy port and checks
// every matrix group against a fixed-point look-at predictor kept in a
// small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
   import lvm_pkg::*;

   localparam int FRAC_BITS  = 16;
   localparam int NUM_RANDOM = 460;
   localparam int IDLE_LIMIT = 4000;   // cycles with no item or result moving
   localparam int DRAIN_WAIT = 400;    // wait after the last predicted group is seen

   // one expected matrix group
   typedef struct {
      bit [1:0] grp;
      int       w [4];
      bit       deg;
      bit       fin;
   } matrix_group_t;

   // Predicts the four view matrix groups of each item and holds them
   // in order until the block sends them.
   class view_matrix_board;
      matrix_group_t groups_due[$];
      int            errors = 0;

      static function longint unsigned magnitude(longint v);
         return (v < 0) ? longint'(-v) : longint'(v);
      endfunction

      // shift right by FRAC_BITS, rounding half away from zero
      static function longint round_shift(longint v);
         longint unsigned m;
         m = (magnitude(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         return (v < 0) ? -longint'(m) : longint'(m);
      endfunction

      static function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned res;
         longint unsigned b;
         res = 0;
         b   = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x   = x - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      // returns 1 on a zero-length vector, leaving the unit vector zero
      static function bit unit_vector(input longint v [3], output longint o [3]);
         longint unsigned m [3];
         longint unsigned mx, sum, n, q;
         mx = 0;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(v[i]);
            if (m[i] > mx) mx = m[i];
            o[i] = 0;
         end
         if (mx == 0) return 1'b1;
         // bring the largest magnitude into [2^29, 2^30)
         while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
         end
         while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
         end
         for (int i = 0; i < 3; i++) sum += m[i] * m[i];
         n = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC_BITS) + (n >> 1)) / n;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
         end
         return 1'b0;
      endfunction

      function void note_item(input int eye [3], input int tgt [3], input int up [3]);
         longint d [3], f [3], c [3], s [3], u [3];
         longint w [4][4];
         bit deg;
         matrix_group_t g;
         for (int i = 0; i < 3; i++) d[i] = longint'(tgt[i]) - longint'(eye[i]);
         deg = unit_vector(d, f);
         c[0] = f[1] * up[2] - longint'(up[1]) * f[2];
         c[1] = f[2] * up[0] - longint'(up[2]) * f[0];
         c[2] = f[0] * up[1] - longint'(up[0]) * f[1];
         if (unit_vector(c, s)) deg = 1'b1;
         u[0] = round_shift(s[1] * f[2] - f[1] * s[2]);
         u[1] = round_shift(s[2] * f[0] - f[2] * s[0]);
         u[2] = round_shift(s[0] * f[1] - f[0] * s[1]);
         for (int i = 0; i < 3; i++) begin
            w[i][0] = s[i];
            w[i][1] = u[i];
            w[i][2] = -f[i];
            w[i][3] = 0;
         end
         w[3][0] = -round_shift(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]);
         w[3][1] = -round_shift(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]);
         w[3][2] = round_shift(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
         w[3][3] = 64'sd1 <<< FRAC_BITS;
         // saturate every word to 32 bits
         for (int r = 0; r < 4; r++)
            for (int k = 0; k < 4; k++) begin
               if (w[r][k] > 64'sh7FFF_FFFF) begin
                  w[r][k] = 64'sh7FFF_FFFF;
                  deg = 1'b1;
               end else if (w[r][k] < -64'sh8000_0000) begin
                  w[r][k] = -64'sh8000_0000;
                  deg = 1'b1;
               end
            end
         for (int r = 0; r < 4; r++) begin
            g.grp = r[1:0];
            for (int k = 0; k < 4; k++) g.w[k] = int'(w[r][k]);
            g.deg = deg;
            g.fin = (r == 3);
            groups_due.push_back(g);
         end
      endfunction

      function void check_result(input bit [1:0] grp, input int w [4], input bit deg,
                                 input bit fin);
         matrix_group_t e;
         if (groups_due.size() == 0) begin
            $display("%0t: unexpected result group %0d", $time, grp);
            errors++;
            return;
         end
         e = groups_due.pop_front();
         if (grp !== e.grp) begin
            $display("%0t: group_index exp %0d got %0d", $time, e.grp, grp);
            errors++;
         end
         for (int k = 0; k < 4; k++)
            if (w[k] !== e.w[k]) begin
               $display("%0t: group %0d word%0d exp %h got %h", $time, e.grp, k,
                        e.w[k], w[k]);
               errors++;
            end
         if (deg !== e.deg) begin
            $display("%0t: group %0d degenerate exp %0b got %0b", $time, e.grp,
                     e.deg, deg);
            errors++;
         end
         if (fin !== e.fin) begin
            $display("%0t: group %0d final_group exp %0b got %0b", $time, e.grp,
                     e.fin, fin);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [31:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_group_index;
   logic signed [31:0] rsp_word0, rsp_word1, rsp_word2, rsp_word3;
   logic               rsp_degenerate;
   logic               rsp_final_group;

   view_matrix_board board = new();
   int               idle_cycles = 0;

   lookat_view_matrix_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(req_eye_x), .req_eye_y(req_eye_y), .req_eye_z(req_eye_z),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z),
      .req_up_x(req_up_x), .req_up_y(req_up_y), .req_up_z(req_up_z),
      .rsp_valid(rsp_valid), .rsp_group_index(rsp_group_index),
      .rsp_word0(rsp_word0), .rsp_word1(rsp_word1), .rsp_word2(rsp_word2),
      .rsp_word3(rsp_word3), .rsp_degenerate(rsp_degenerate),
      .rsp_final_group(rsp_final_group)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: the block pushes one group per strobe, no back-pressure.
   always @(posedge clock) begin
      int w [4];
      if (!reset && rsp_valid) begin
         w = '{rsp_word0, rsp_word1, rsp_word2, rsp_word3};
         board.check_result(rsp_group_index, w, rsp_degenerate, rsp_final_group);
      end
   end

   // Watchdog: counts cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Drive one item from the falling edge and hold it until busy is low at a
   // rising edge. start stays high; the caller lowers it for a gap.
   task automatic send_item(input int ex, ey, ez, tx, ty, tz, ux, uy, uz);
      int e [3], t [3], u [3];
      e = '{ex, ey, ez};
      t = '{tx, ty, tz};
      u = '{ux, uy, uz};
      @(negedge clock);
      start        = 1'b1;
      req_eye_x    = ex;
      req_eye_y    = ey;
      req_eye_z    = ez;
      req_target_x = tx;
      req_target_y = ty;
      req_target_z = tz;
      req_up_x     = ux;
      req_up_y     = uy;
      req_up_z     = uz;
      do @(posedge clock); while (busy);
      board.note_item(e, t, u);
   endtask

   // Block until every predicted group has been seen.
   task automatic wait_drained();
      while (board.groups_due.size() != 0) @(posedge clock);
   endtask

   // Mostly back-to-back, some short gaps, a few long ones.
   task automatic sender_gap();
      int pick, n;
      pick = $urandom_range(0, 99);
      if (pick < 60) return;
      n = (pick < 94) ? $urandom_range(1, 6) : $urandom_range(40, 400);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Typical scene coordinate: within +-16 units, sometimes tiny.
   function automatic int scene_coord();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 64) - 32;
      return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
   endfunction

   localparam int ONE  = 32'h0001_0000;
   localparam int PMAX = 32'h7FFF_FFFF;
   localparam int NMIN = 32'h8000_0000;

   initial begin
      int e [3], t [3], u [3];
      int kind;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items
      // axis-aligned camera looking down -z, up +y
      send_item(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
      send_item(ONE, 2 * ONE, 3 * ONE, -ONE, 0, ONE, 0, 0, ONE);
      // target equals eye: zero forward vector
      send_item(3 * ONE, -ONE, 7, 3 * ONE, -ONE, 7, 0, ONE, 0);
      // all zero
      send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
      // up parallel to forward, and antiparallel
      send_item(0, 0, 0, 0, 4 * ONE, 0, 0, ONE, 0);
      send_item(0, 0, 0, 0, 0, -ONE, 0, 0, 5 * ONE);
      // zero up vector
      send_item(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0);
      // extreme coordinates, widest difference and saturating dot products
      send_item(PMAX, PMAX, PMAX, NMIN, NMIN, NMIN, 0, ONE, 0);
      send_item(NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, NMIN, PMAX, NMIN);
      send_item(NMIN, 0, PMAX, PMAX, NMIN, 0, PMAX, PMAX, PMAX);
      send_item(PMAX, NMIN, PMAX, PMAX, NMIN, PMAX - 1, -1, -1, -1);
      // smallest nonzero differences, up at full range and at its smallest
      send_item(0, 0, 0, 1, 0, 0, 0, PMAX, 0);
      send_item(-1, -1, -1, 0, 0, 0, NMIN, 0, 1);
      send_item(0, 0, 0, 1, 1, 1, 1, 0, 0);
      // all ones and alternating bit patterns
      send_item(-1, -1, -1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, -1, -1, -1,
                32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

      // Hold off until the block has drained once.
      @(negedge clock);
      start = 1'b0;
      wait_drained();

      // Random items: mostly realistic scenes, some full-range noise and
      // some degenerate setups.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         kind = $urandom_range(0, 99);
         for (int i = 0; i < 3; i++) begin
            if (kind < 65) begin
               e[i] = scene_coord();
               t[i] = scene_coord();
               u[i] = scene_coord();
            end else begin
               e[i] = $urandom;
               t[i] = $urandom;
               u[i] = $urandom;
            end
         end
         if (kind >= 85 && kind < 91) t = e;
         else if (kind >= 91 && kind < 97)
            for (int i = 0; i < 3; i++) u[i] = (t[i] - e[i]) * $urandom_range(1, 3);
         else if (kind >= 97)
            u = '{0, 0, 0};
         send_item(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
         if (n == NUM_RANDOM / 2) begin
            @(negedge clock);
            start = 1'b0;
            wait_drained();
         end else begin
            sender_gap();
         end
      end
      @(negedge clock);
      start = 1'b0;

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.groups_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
